>>> rtl/core/dns_record_parser_assert.svh
// Assertion macros for the DNS record parser.
`ifndef DNS_RECORD_PARSER_ASSERT_SVH
`define DNS_RECORD_PARSER_ASSERT_SVH
`ifndef SYNTH
`define DRP_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DRP_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define DRP_ASSERT_IMP(label, a, c)
`define DRP_ASSERT_NXT(label, a, c)
`endif
`endif

>>> rtl/core/drp_pkg.sv
`timescale 1ns / 1ps
package drp_pkg;
    typedef struct packed {
        logic [7:0] wire_byte;
        logic       buffer_end;
        logic       question_record;
    } drp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [15:0] rdata_length;
        logic [16:0] consumed;
        logic        name_compressed;
        logic [1:0]  error_code;
        logic        last;
    } drp_out_t;

    typedef enum logic [2:0] {
        PH_START, PH_PTR2, PH_LABEL, PH_CHAR, PH_FIXED, PH_RDATA, PH_DRAIN
    } drp_phase_t;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_RDATA = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;
    localparam logic [1:0] ERR_BAD    = 2'd0;
    localparam logic [1:0] ERR_LONG   = 2'd1;
    localparam logic [1:0] ERR_TRUNC  = 2'd2;
    localparam logic [7:0] PTR_MIN    = 8'd192;
    localparam logic [7:0] LABEL_MAX  = 8'd63;
    localparam int         QDEPTH     = 4;
endpackage

>>> rtl/core/drp_front.sv
`timescale 1ns / 1ps
module drp_front import drp_pkg::*; #(
    parameter int NAME_LIMIT = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  drp_in_t  din,
    output logic     has0,
    output logic     has1,
    output drp_out_t res0,
    output drp_out_t res1
);
    localparam int CW = $clog2(NAME_LIMIT + 64) + 1;

    drp_phase_t phase_reg, phase_next;
    logic [CW-1:0] wire_reg, wire_next, text_reg, text_next;
    logic [5:0] left_reg, left_next;
    logic first_reg, first_next;
    logic [3:0] fidx_reg, fidx_next;
    logic [15:0] type_reg, type_next, class_reg, class_next, rdlen_reg, rdlen_next;
    logic [15:0] rleft_reg, rleft_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [16:0] bytes_reg, bytes_next;
    logic q_reg, q_next, ptr_reg, ptr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START; wire_reg <= '0; text_reg <= '0; left_reg <= '0;
            first_reg <= 1'b1; fidx_reg <= '0; type_reg <= '0; class_reg <= '0;
            ttl_reg <= '0; rdlen_reg <= '0; rleft_reg <= '0; bytes_reg <= '0;
            q_reg <= 1'b0; ptr_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; wire_reg <= wire_next; text_reg <= text_next;
            left_reg <= left_next; first_reg <= first_next; fidx_reg <= fidx_next;
            type_reg <= type_next; class_reg <= class_next; ttl_reg <= ttl_next;
            rdlen_reg <= rdlen_next; rleft_reg <= rleft_next; bytes_reg <= bytes_next;
            q_reg <= q_next; ptr_reg <= ptr_next;
        end
    end

    always_comb
    begin
        logic [7:0] b;
        logic [1:0] err;
        logic is_err, done, dot, chr, rdb, fresh;
        logic [CW-1:0] bw, t;
        b = din.wire_byte; bw = CW'(b);
        err = ERR_BAD; is_err = 1'b0; done = 1'b0; dot = 1'b0; chr = 1'b0; rdb = 1'b0;
        t = '0;
        fresh = (phase_reg == PH_START);
        phase_next = phase_reg;
        wire_next = fresh ? '0 : wire_reg;
        text_next = fresh ? '0 : text_reg;
        left_next = fresh ? '0 : left_reg;
        first_next = fresh ? 1'b1 : first_reg;
        fidx_next = fresh ? '0 : fidx_reg;
        type_next = fresh ? '0 : type_reg;
        class_next = fresh ? '0 : class_reg;
        ttl_next = fresh ? '0 : ttl_reg;
        rdlen_next = fresh ? '0 : rdlen_reg;
        rleft_next = fresh ? '0 : rleft_reg;
        bytes_next = (fresh ? 17'd0 : bytes_reg) + 17'd1;
        ptr_next = fresh ? 1'b0 : ptr_reg;
        q_next = fresh ? din.question_record : q_reg;
        if (phase_reg == PH_DRAIN)
        begin
            bytes_next = bytes_reg;
            if (din.buffer_end) phase_next = PH_START;
        end
        else
        begin
            if ((fresh && b >= PTR_MIN))
            begin
                ptr_next = 1'b1; phase_next = PH_PTR2;
            end
            else if (fresh || phase_reg == PH_LABEL)
            begin
                // length byte of the name
                if (wire_next >= CW'(NAME_LIMIT))
                begin
                    is_err = 1'b1; err = ERR_LONG;
                end
                else
                begin
                    wire_next = wire_next + 1'b1;
                    t = text_next + (first_next ? CW'(0) : CW'(1));
                    if (b == 8'd0)
                    begin
                        phase_next = PH_FIXED; fidx_next = '0;
                    end
                    else if (b > LABEL_MAX)
                    begin
                        is_err = 1'b1; err = ERR_BAD;
                    end
                    else if (wire_next + bw >= CW'(NAME_LIMIT)
                             || (!first_next && text_next >= CW'(NAME_LIMIT - 1))
                             || t + bw > CW'(NAME_LIMIT - 1))
                    begin
                        is_err = 1'b1; err = ERR_LONG;
                    end
                    else
                    begin
                        dot = !first_next;
                        text_next = t; first_next = 1'b0;
                        left_next = b[5:0]; phase_next = PH_CHAR;
                    end
                end
            end
            else if (phase_reg == PH_PTR2)
            begin
                phase_next = PH_FIXED; fidx_next = '0;
            end
            else if (phase_reg == PH_CHAR)
            begin
                wire_next = wire_reg + 1'b1; text_next = text_reg + 1'b1; chr = 1'b1;
                left_next = left_reg - 6'd1;
                if (left_next == 6'd0) phase_next = PH_LABEL;
            end
            else if (phase_reg == PH_FIXED)
            begin
                if (fidx_reg < 4'd2) type_next = {type_reg[7:0], b};
                else if (fidx_reg < 4'd4) class_next = {class_reg[7:0], b};
                else if (fidx_reg < 4'd8) ttl_next = {ttl_reg[23:0], b};
                else rdlen_next = {rdlen_reg[7:0], b};
                if (fidx_reg == 4'd3 && q_reg) done = 1'b1;
                else if (fidx_reg >= 4'd9)
                begin
                    rleft_next = rdlen_next;
                    if (rdlen_next == 16'd0) done = 1'b1;
                    else phase_next = PH_RDATA;
                end
                fidx_next = fidx_reg + 4'd1;
            end
            else
            begin
                rdb = 1'b1; rleft_next = rleft_reg - 16'd1;
                if (rleft_next == 16'd0) done = 1'b1;
            end
            if (is_err) phase_next = din.buffer_end ? PH_START : PH_DRAIN;
            else if (done) phase_next = PH_START;
            else if (din.buffer_end)
            begin
                is_err = 1'b1; err = ERR_TRUNC; phase_next = PH_START;
            end
        end
        // first slot: data byte or dot; second: closing word
        res0 = '0; res1 = '0;
        has0 = dot || chr || rdb;
        res0.kind = rdb ? KIND_RDATA : KIND_CHAR;
        res0.out_byte = dot ? 8'h2e : b;
        has1 = is_err || done;
        if (is_err)
        begin
            res1.kind = KIND_ERROR; res1.error_code = err; res1.last = 1'b1;
        end
        else
        begin
            res1.kind = KIND_DONE;
            res1.record_type = type_next; res1.record_class = class_next;
            res1.time_to_live = q_next ? 32'd0 : ttl_next;
            res1.rdata_length = q_next ? 16'd0 : rdlen_next;
            res1.consumed = bytes_next; res1.name_compressed = ptr_next;
            res1.last = 1'b1;
        end
    end
endmodule

>>> rtl/core/drp_queue.sv
`timescale 1ns / 1ps
module drp_queue import drp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push0,
    input  logic     push1,
    input  drp_out_t d0,
    input  drp_out_t d1,
    output logic     room,
    output logic     valid,
    input  logic     ready,
    output drp_out_t result
);
    localparam int AW = $clog2(QDEPTH);
    drp_out_t mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic pop;
    logic [1:0] npush;

    assign pop = valid && ready;
    assign valid = (cnt_reg != '0);
    assign result = mem[rp_reg];
    assign npush = {1'b0, push0} + {1'b0, push1};
    // need room for two words; a word leaving this cycle is not counted
    assign room = (cnt_reg <= (AW+1)'(QDEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push0) mem[wp_reg] <= d0;
        if (push1) mem[push0 ? wp_reg + 1'b1 : wp_reg] <= d1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_reg + AW'(npush);
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(npush) - (AW+1)'(pop);
        end
    end
endmodule

>>> rtl/core/dns_record_parser.sv
`timescale 1ns / 1ps
// DNS resource record parser: one wire byte per cycle in, name characters, rdata
// bytes, record summaries and errors out. The front parses each byte combinationally
// and writes up to two words into a four-entry queue; the input is taken every
// cycle while the queue has room for two words, so throughput is one byte a cycle
// as long as the output side takes one word a cycle.
`include "dns_record_parser_assert.svh"
module dns_record_parser import drp_pkg::*; #(
    parameter int NAME_LIMIT = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  drp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output drp_out_t out_data
);
    logic step, has0, has1;
    drp_out_t res0, res1;

    assign step = in_valid && in_ready;

    drp_front #(.NAME_LIMIT(NAME_LIMIT)) u_front (
        .clk(clk), .rst_n(rst_n), .step(step), .din(in_data),
        .has0(has0), .has1(has1), .res0(res0), .res1(res1)
    );

    drp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push0(step && has0), .push1(step && has1),
        .d0(res0), .d1(res1), .room(in_ready), .valid(out_valid),
        .ready(out_ready), .result(out_data)
    );

    `DRP_ASSERT_IMP(a_last_kind, out_valid, out_data.last == (out_data.kind[1] == 1'b1))
    `DRP_ASSERT_NXT(a_push_valid, step && (has0 || has1), out_valid)
    `DRP_ASSERT_IMP(a_err_code, out_valid && out_data.kind == KIND_ERROR,
                    out_data.error_code != 2'd3)
endmodule
